### rtl/apss_pkg.sv
// Shared types, state and event codes for the ACPI power-state sequencer.
package apss_pkg;

  localparam int STATE_W    = 4;
  localparam int EVENT_W    = 4;
  localparam int MAX_EVENTS = 4;
  localparam int EV_IDX_W   = 2;
  localparam int TIMER_W    = 20;
  localparam int SIG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int TICK_QUEUE_DEPTH   = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  // power states
  localparam logic [STATE_W-1:0] ST_G3     = 4'd0;
  localparam logic [STATE_W-1:0] ST_S5     = 4'd1;
  localparam logic [STATE_W-1:0] ST_S4     = 4'd2;
  localparam logic [STATE_W-1:0] ST_S3     = 4'd3;
  localparam logic [STATE_W-1:0] ST_S0IX   = 4'd4;
  localparam logic [STATE_W-1:0] ST_S0     = 4'd5;
  localparam logic [STATE_W-1:0] ST_G3S5   = 4'd6;
  localparam logic [STATE_W-1:0] ST_S5S4   = 4'd7;
  localparam logic [STATE_W-1:0] ST_S4S3   = 4'd8;
  localparam logic [STATE_W-1:0] ST_S3S0   = 4'd9;
  localparam logic [STATE_W-1:0] ST_S5G3   = 4'd10;
  localparam logic [STATE_W-1:0] ST_S4S5   = 4'd11;
  localparam logic [STATE_W-1:0] ST_S3S4   = 4'd12;
  localparam logic [STATE_W-1:0] ST_S0S3   = 4'd13;
  localparam logic [STATE_W-1:0] ST_S0IXS0 = 4'd14;
  localparam logic [STATE_W-1:0] ST_S0S0IX = 4'd15;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE            = 4'd0;
  localparam logic [EVENT_W-1:0] EV_FORCE_OFF_G3    = 4'd1;
  localparam logic [EVENT_W-1:0] EV_SHUTDOWN        = 4'd2;
  localparam logic [EVENT_W-1:0] EV_SHUTDOWN_DONE   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_HARD_OFF        = 4'd4;
  localparam logic [EVENT_W-1:0] EV_STARTUP         = 4'd5;
  localparam logic [EVENT_W-1:0] EV_CLEAR_HOST_SLP  = 4'd6;
  localparam logic [EVENT_W-1:0] EV_RESUME_INIT     = 4'd7;
  localparam logic [EVENT_W-1:0] EV_RESUME          = 4'd8;
  localparam logic [EVENT_W-1:0] EV_SUSPEND         = 4'd9;
  localparam logic [EVENT_W-1:0] EV_SUSPEND_DONE    = 4'd10;
  localparam logic [EVENT_W-1:0] EV_SLEEP_SUSPEND   = 4'd11;
  localparam logic [EVENT_W-1:0] EV_SLEEP_RESUME    = 4'd12;
  localparam logic [EVENT_W-1:0] EV_FORCE_OFF_PFAIL = 4'd13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_G3S5_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_G3S5_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S5_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_S5_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_S0IX_EN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_HOOK   = 3'd6;

  // S5 timeout modes
  localparam logic [1:0] S5_TMO_OFF   = 2'd0;
  localparam logic [1:0] S5_TMO_IMMED = 2'd1;
  localparam logic [1:0] S5_TMO_TIMED = 2'd2;

  // host sleep notify
  localparam logic [1:0] HOST_SUSPEND = 2'd1;
  localparam logic [1:0] HOST_RESUME  = 2'd2;

  typedef struct packed {
    logic             exit_request;
    logic [SIG_W-1:0] signal_vector;
    logic             slp_s0_on;
    logic             slp_s3_on;
    logic             slp_s4_on;
    logic             slp_s5_on;
    logic [2:0]       slp_valid;
    logic             pgood_all_core;
    logic             all_sys_pwrgd;
    logic [2:0]       rails_ok;
    logic             rsmrst_good;
    logic [1:0]       host_sleep_state;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0] power_state;
    logic [EVENT_W-1:0] event_code;
    logic               last_event;
    logic               rsmrst_drive;
    logic               deep_sleep_allowed;
    logic               state_changed;
  } result_t;

  // one tick's outcome, handed from the front to the back
  typedef struct packed {
    logic [STATE_W-1:0]                 power_state;
    logic [MAX_EVENTS-1:0][EVENT_W-1:0] events;
    logic [EV_IDX_W-1:0]                last_idx;
    logic                               rsmrst_drive;
    logic                               deep_sleep_allowed;
    logic                               state_changed;
  } tick_t;

endpackage

### rtl/apss_fifo.sv
// Small register FIFO used between the sequencer stages.
module apss_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/apss_front.sv
// Front stage: configuration registers, sleep-state machine step and event list per tick.
module apss_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [apss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          take,
  input  apss_pkg::item_t               item,
  output apss_pkg::tick_t               tick
);
  import apss_pkg::*;

  // configuration
  logic [SIG_W-1:0]   g3s5_mask;
  logic [SIG_W-1:0]   g3s5_value;
  logic [TIMER_W-1:0] reboot_ticks;
  logic [1:0]         s5_mode;
  logic [TIMER_W-1:0] s5_ticks;
  logic               s0ix_en;
  logic               hook_en;

  // machine state
  logic [STATE_W-1:0] state;
  logic               exit_pending;
  logic [TIMER_W-1:0] reboot_count;
  logic [TIMER_W-1:0] s5_count;
  logic               s5_running;
  logic               rsmrst_level;
  logic               sleep_allowed;

  logic [STATE_W-1:0] state_next;
  logic               exit_pending_next;
  logic [TIMER_W-1:0] reboot_count_next;
  logic               reboot_ticks_clear;
  logic [TIMER_W-1:0] s5_count_next;
  logic               s5_running_next;
  logic               rsmrst_level_next;
  logic               sleep_allowed_next;

  logic [MAX_EVENTS-1:0][EVENT_W-1:0] evs;
  logic [EV_IDX_W:0]                  ev_cnt;
  logic [TIMER_W-1:0]                 s5_count_inc;
  logic                               s5_left;
  logic s3_on, s3_off, s4_on, s4_off, s5_on, s5_off;

  // an invalid virtual wire fails both tests
  assign s3_on  = item.slp_valid[0] &&  item.slp_s3_on;
  assign s3_off = item.slp_valid[0] && !item.slp_s3_on;
  assign s4_on  = item.slp_valid[1] &&  item.slp_s4_on;
  assign s4_off = item.slp_valid[1] && !item.slp_s4_on;
  assign s5_on  = item.slp_valid[2] &&  item.slp_s5_on;
  assign s5_off = item.slp_valid[2] && !item.slp_s5_on;

  assign s5_count_inc = (s5_count != '1) ? s5_count + TIMER_W'(1) : s5_count;

  always_comb begin
    state_next         = state;
    exit_pending_next  = exit_pending | item.exit_request;
    reboot_count_next  = reboot_count;
    reboot_ticks_clear = 1'b0;
    s5_count_next      = s5_count;
    s5_running_next    = s5_running;
    rsmrst_level_next  = rsmrst_level;
    sleep_allowed_next = sleep_allowed;
    evs                = {MAX_EVENTS{EV_NONE}};
    ev_cnt             = '0;
    s5_left            = 1'b0;

    unique case (state)
      ST_G3: begin
        if (exit_pending_next) begin
          if (reboot_count < reboot_ticks) begin
            reboot_count_next = reboot_count + TIMER_W'(1);
          end else begin
            exit_pending_next  = 1'b0;
            reboot_count_next  = '0;
            reboot_ticks_clear = 1'b1;
            state_next         = ST_G3S5;
          end
        end
      end
      ST_G3S5: begin
        state_next = ((item.signal_vector & g3s5_mask) == g3s5_value) ? ST_S5 : ST_S5G3;
      end
      ST_S5: begin
        if (item.rails_ok == 3'b111 && item.rsmrst_good) begin
          rsmrst_level_next = 1'b1;
          if (s5_off) begin
            state_next = ST_S5S4;
            s5_left    = 1'b1;
          end
        end
        if (!s5_left) begin
          if (s5_mode == S5_TMO_IMMED) begin
            state_next = ST_S5G3;
          end else if (s5_mode == S5_TMO_TIMED) begin
            if (s5_running) begin
              s5_count_next = s5_count_inc;
              if (s5_count_inc >= s5_ticks) begin
                state_next = ST_S5G3;
              end
            end else begin
              s5_running_next = 1'b1;
              s5_count_next   = '0;
            end
          end
        end
      end
      ST_S5G3: begin
        evs        = {EV_HARD_OFF, EV_SHUTDOWN_DONE, EV_SHUTDOWN, EV_FORCE_OFF_G3};
        ev_cnt     = 3'd4;
        state_next = ST_G3;
      end
      ST_S5S4: begin
        state_next = item.rsmrst_good ? ST_S4 : ST_S5;
      end
      ST_S4: begin
        if (s5_on) begin
          state_next = ST_S4S5;
        end else if (s4_off) begin
          state_next = ST_S4S3;
        end
      end
      ST_S4S3: begin
        if (!item.pgood_all_core) begin
          evs[0] = EV_FORCE_OFF_PFAIL; evs[1] = EV_SHUTDOWN; evs[2] = EV_SHUTDOWN_DONE;
          ev_cnt = 3'd3;
          state_next = ST_G3;
        end else begin
          evs[0] = EV_STARTUP;
          ev_cnt = 3'd1;
          if (s0ix_en) begin
            evs[1] = EV_CLEAR_HOST_SLP;
            ev_cnt = 3'd2;
          end
          state_next = ST_S3;
        end
      end
      ST_S3: begin
        if (!item.pgood_all_core) begin
          evs[0] = EV_FORCE_OFF_PFAIL; evs[1] = EV_SHUTDOWN; evs[2] = EV_SHUTDOWN_DONE;
          ev_cnt = 3'd3;
          state_next = ST_G3;
        end else if (s3_off) begin
          state_next = ST_S3S0;
        end else if (s4_on) begin
          state_next = ST_S3S4;
        end
      end
      ST_S3S0: begin
        if (!item.pgood_all_core) begin
          evs[0] = EV_FORCE_OFF_PFAIL; evs[1] = EV_SHUTDOWN; evs[2] = EV_SHUTDOWN_DONE;
          ev_cnt = 3'd3;
          state_next = ST_G3;
        end else if (item.all_sys_pwrgd) begin
          if (hook_en) begin
            evs[0] = EV_RESUME_INIT; evs[1] = EV_RESUME;
            ev_cnt = 3'd2;
          end else begin
            evs[0] = EV_RESUME;
            ev_cnt = 3'd1;
          end
          state_next = ST_S0;
        end
      end
      ST_S0IX: begin
        if (!item.slp_s0_on && s3_off) begin
          state_next = ST_S0IXS0;
        end else if (!item.pgood_all_core) begin
          state_next = ST_S0;
        end
      end
      ST_S0S0IX: begin
        if (item.host_sleep_state == HOST_SUSPEND) begin
          evs[ev_cnt[EV_IDX_W-1:0]] = EV_SLEEP_SUSPEND;
          ev_cnt = ev_cnt + 3'd1;
        end
        if (hook_en) begin
          evs[ev_cnt[EV_IDX_W-1:0]] = EV_SUSPEND_DONE;
          ev_cnt = ev_cnt + 3'd1;
        end
        sleep_allowed_next = 1'b1;
        state_next = ST_S0IX;
      end
      ST_S0IXS0: begin
        sleep_allowed_next = 1'b0;
        if (hook_en) begin
          evs[0] = EV_RESUME_INIT;
          ev_cnt = 3'd1;
        end
        state_next = ST_S0;
      end
      ST_S0: begin
        if (!item.pgood_all_core) begin
          evs[0] = EV_FORCE_OFF_PFAIL; evs[1] = EV_SHUTDOWN; evs[2] = EV_SHUTDOWN_DONE;
          ev_cnt = 3'd3;
          state_next = ST_G3;
        end else if (s3_on) begin
          state_next = ST_S0S3;
        end else if (s0ix_en && item.host_sleep_state == HOST_SUSPEND && item.slp_s0_on) begin
          state_next = ST_S0S0IX;
        end else if (s0ix_en && item.host_sleep_state == HOST_RESUME) begin
          evs[0] = EV_SLEEP_RESUME;
          ev_cnt = 3'd1;
        end
      end
      ST_S4S5: begin
        evs[0] = EV_SHUTDOWN; evs[1] = EV_SHUTDOWN_DONE;
        ev_cnt = 3'd2;
        state_next = ST_S5;
      end
      ST_S3S4: begin
        state_next = ST_S4;
      end
      ST_S0S3: begin
        evs[0] = EV_SUSPEND;
        ev_cnt = 3'd1;
        if (hook_en) begin
          evs[ev_cnt[EV_IDX_W-1:0]] = EV_SUSPEND_DONE;
          ev_cnt = ev_cnt + 3'd1;
        end
        sleep_allowed_next = 1'b1;
        if (s0ix_en) begin
          evs[ev_cnt[EV_IDX_W-1:0]] = EV_CLEAR_HOST_SLP;
          ev_cnt = ev_cnt + 3'd1;
        end
        state_next = ST_S3;
      end
    endcase

    // timer restarts on every S5 entry
    if (state == ST_S5 && state_next != ST_S5) begin
      s5_running_next = 1'b0;
      s5_count_next   = '0;
    end

    // a quiet tick still yields one result
    if (ev_cnt == '0) begin
      ev_cnt = 3'd1;
    end
  end

  always_comb begin
    tick.power_state        = state_next;
    tick.events             = evs;
    tick.last_idx           = EV_IDX_W'(ev_cnt - 3'd1);
    tick.rsmrst_drive       = rsmrst_level_next;
    tick.deep_sleep_allowed = sleep_allowed_next;
    tick.state_changed      = (state_next != state);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_G3;
      exit_pending  <= 1'b0;
      reboot_count  <= '0;
      s5_count      <= '0;
      s5_running    <= 1'b0;
      rsmrst_level  <= 1'b0;
      sleep_allowed <= 1'b0;
    end else if (take) begin
      state         <= state_next;
      exit_pending  <= exit_pending_next;
      reboot_count  <= reboot_count_next;
      s5_count      <= s5_count_next;
      s5_running    <= s5_running_next;
      rsmrst_level  <= rsmrst_level_next;
      sleep_allowed <= sleep_allowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g3s5_mask    <= '0;
      g3s5_value   <= '0;
      reboot_ticks <= '0;
      s5_mode      <= S5_TMO_OFF;
      s5_ticks     <= TIMER_W'(1);
      s0ix_en      <= 1'b0;
      hook_en      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_G3S5_MASK:    g3s5_mask    <= cfg_data[SIG_W-1:0];
        CFG_G3S5_VALUE:   g3s5_value   <= cfg_data[SIG_W-1:0];
        CFG_REBOOT_DELAY: reboot_ticks <= cfg_data[TIMER_W-1:0];
        CFG_S5_MODE:      s5_mode      <= cfg_data[1:0];
        CFG_S5_TICKS:     s5_ticks     <= cfg_data[TIMER_W-1:0];
        CFG_S0IX_EN:      s0ix_en      <= cfg_data[0];
        CFG_RESUME_HOOK:  hook_en      <= cfg_data[0];
        default: ;
      endcase
    end else if (take && reboot_ticks_clear) begin
      // reboot delay is one-shot
      reboot_ticks <= '0;
    end
  end

endmodule

### rtl/apss_back.sv
// Back stage: walks one tick's event list, one result per cycle while the result queue has room.
module apss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_empty,
  input  apss_pkg::tick_t   tick,
  output logic              tick_pop,
  input  logic              res_full,
  output logic              res_push,
  output apss_pkg::result_t res
);
  import apss_pkg::*;

  logic [EV_IDX_W-1:0] idx;
  logic                last;

  assign last     = (idx == tick.last_idx);
  assign res_push = !tick_empty && !res_full;
  assign tick_pop = res_push && last;

  always_comb begin
    res.power_state        = tick.power_state;
    res.event_code         = tick.events[idx];
    res.last_event         = last;
    res.rsmrst_drive       = tick.rsmrst_drive;
    res.deep_sleep_allowed = tick.deep_sleep_allowed;
    res.state_changed      = tick.state_changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (res_push) begin
      idx <= last ? '0 : idx + EV_IDX_W'(1);
    end
  end

endmodule

### rtl/acpi_power_state_sequencer.sv
// Top level: front step stage, tick queue, event walker and result queue.
// A tick is registered in the tick queue and each of its results in the result queue; the
// back stage between them is combinational.
// Throughput: one tick per cycle enters while the tick queue has room; the back stage puts out
// one result per cycle while the result queue has room: one result per event, one to four per tick.
// Reset (rst, synchronous): state G3, timers and latches clear, registers at defaults, queues empty.
module acpi_power_state_sequencer #(
  parameter int TICK_DEPTH   = apss_pkg::TICK_QUEUE_DEPTH,
  parameter int RESULT_DEPTH = apss_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [apss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  apss_pkg::item_t                 in_item,
  output logic                            empty,
  input  logic                            pop,
  output apss_pkg::result_t               result
);
  import apss_pkg::*;

  logic    take;
  tick_t   tick_in;
  tick_t   tick_head;
  logic    tick_empty;
  logic    tick_pop;
  logic    res_full;
  logic    res_push;
  result_t res;

  assign take = push && !full;

  apss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_item),
    .tick      (tick_in)
  );

  apss_fifo #(
    .DEPTH (TICK_DEPTH),
    .T     (tick_t)
  ) u_tick_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (tick_in),
    .full    (full),
    .rd_en   (tick_pop),
    .rd_data (tick_head),
    .empty   (tick_empty)
  );

  apss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tick_empty (tick_empty),
    .tick       (tick_head),
    .tick_pop   (tick_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  apss_fifo #(
    .DEPTH (RESULT_DEPTH),
    .T     (result_t)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

### rtl/apss_checker.sv
// Port-level checks for the sequencer, bound to the top level.
module apss_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input apss_pkg::result_t result
);
  import apss_pkg::*;

  // the result queue comes out of reset empty and the tick queue not full
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before transfer");

  a_none_alone: assert property (@(posedge clk) disable iff (rst)
    !empty && result.event_code == EV_NONE |-> result.last_event)
    else $error("quiet result not alone in its tick");

  a_hard_off: assert property (@(posedge clk) disable iff (rst)
    !empty && result.event_code == EV_HARD_OFF |->
      result.power_state == ST_G3 && result.last_event && result.state_changed)
    else $error("hard-off result inconsistent");

  a_pfail: assert property (@(posedge clk) disable iff (rst)
    !empty && result.event_code == EV_FORCE_OFF_PFAIL |->
      result.power_state == ST_G3 && !result.last_event)
    else $error("power-fail result inconsistent");

endmodule

bind acpi_power_state_sequencer apss_checker u_apss_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

### verif/acpi_power_state_sequencer_test.sv
// Self-checking testbench for the ACPI power-state sequencer: walks the sleep-state machine.
`timescale 1ns / 1ps

module acpi_power_state_sequencer_test;
  import apss_pkg::*;

  localparam int         DRAIN_CYCLES  = 8;
  localparam int         LONG_HOLD     = 60;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam logic [1:0] S5_TMO_UNUSED = 2'd3;

  typedef enum int {
    FL_BOOT, FL_SLEEP_S3, FL_SLEEP_S4, FL_OFF, FL_IX_ENTER, FL_IX_EXIT, FL_PFAIL, FL_NOISE
  } flavor_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  item_t                 in_item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;

  acpi_power_state_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // sequencer shadow: configuration
  logic [SIG_W-1:0]   g3s5_mask    = '0;
  logic [SIG_W-1:0]   g3s5_value   = '0;
  logic [TIMER_W-1:0] reboot_ticks = '0;
  logic [1:0]         s5_mode      = S5_TMO_OFF;
  logic [TIMER_W-1:0] s5_ticks     = 20'd1;
  logic               s0ix_on      = 1'b0;
  logic               hook_on      = 1'b0;

  // sequencer shadow: state
  logic [STATE_W-1:0] pw_state     = ST_G3;
  logic               exit_latched = 1'b0;
  logic [TIMER_W-1:0] reboot_cnt   = '0;
  logic [TIMER_W-1:0] s5_cnt       = '0;
  logic               s5_run       = 1'b0;
  logic               rsmrst_lvl   = 1'b0;
  logic               deep_ok      = 1'b0;

  logic [EVENT_W-1:0] tick_events[$];
  result_t            expected_results[$];
  item_t              pending_items[$];

  int errors = 0;
  int cycle_count = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int sink_hold_cnt = 0;
  bit sink_hold_go = 1'b0;
  bit sink_hold_done = 1'b0;
  bit no_gaps = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void add_event(logic [EVENT_W-1:0] code);
    if (tick_events.size() < MAX_EVENTS) tick_events.push_back(code);
  endfunction

  function automatic void add_powerfail();
    add_event(EV_FORCE_OFF_PFAIL);
    add_event(EV_SHUTDOWN);
    add_event(EV_SHUTDOWN_DONE);
  endfunction

  // one tick of the sequencer; queues the results it raises
  function automatic void predict_tick(item_t it);
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] nxt;
    result_t            r;
    cur = pw_state;
    nxt = cur;
    tick_events.delete();
    if (it.exit_request) exit_latched = 1'b1;
    case (cur)
      ST_G3: begin
        if (exit_latched) begin
          if (reboot_cnt < reboot_ticks) begin
            reboot_cnt++;
          end else begin
            exit_latched = 1'b0;
            reboot_cnt   = '0;
            reboot_ticks = '0;  // delay is one-shot
            nxt          = ST_G3S5;
          end
        end
      end
      ST_G3S5: nxt = ((it.signal_vector & g3s5_mask) == g3s5_value) ? ST_S5 : ST_S5G3;
      ST_S5: begin
        if (it.rails_ok == 3'b111 && it.rsmrst_good) begin
          rsmrst_lvl = it.rsmrst_good;
          if (it.slp_valid[2] && !it.slp_s5_on) nxt = ST_S5S4;
        end
        if (nxt == ST_S5) begin
          if (s5_mode == S5_TMO_IMMED) begin
            nxt = ST_S5G3;
          end else if (s5_mode == S5_TMO_TIMED) begin
            if (s5_run) begin
              if (s5_cnt != '1) s5_cnt++;
              if (s5_cnt >= s5_ticks) nxt = ST_S5G3;
            end else begin
              s5_run = 1'b1;
              s5_cnt = '0;
            end
          end
        end
      end
      ST_S5G3: begin
        add_event(EV_FORCE_OFF_G3);
        add_event(EV_SHUTDOWN);
        add_event(EV_SHUTDOWN_DONE);
        add_event(EV_HARD_OFF);
        nxt = ST_G3;
      end
      ST_S5S4: nxt = it.rsmrst_good ? ST_S4 : ST_S5;
      ST_S4: begin
        if (it.slp_valid[2] && it.slp_s5_on) nxt = ST_S4S5;
        else if (it.slp_valid[1] && !it.slp_s4_on) nxt = ST_S4S3;
      end
      ST_S4S3: begin
        if (!it.pgood_all_core) begin
          add_powerfail();
          nxt = ST_G3;
        end else begin
          add_event(EV_STARTUP);
          if (s0ix_on) add_event(EV_CLEAR_HOST_SLP);
          nxt = ST_S3;
        end
      end
      ST_S3: begin
        if (!it.pgood_all_core) begin
          add_powerfail();
          nxt = ST_G3;
        end else if (it.slp_valid[0] && !it.slp_s3_on) begin
          nxt = ST_S3S0;
        end else if (it.slp_valid[1] && it.slp_s4_on) begin
          nxt = ST_S3S4;
        end
      end
      ST_S3S0: begin
        if (!it.pgood_all_core) begin
          add_powerfail();
          nxt = ST_G3;
        end else if (it.all_sys_pwrgd) begin
          if (hook_on) add_event(EV_RESUME_INIT);
          add_event(EV_RESUME);
          nxt = ST_S0;
        end
      end
      ST_S0IX: begin
        if (!it.slp_s0_on && it.slp_valid[0] && !it.slp_s3_on) nxt = ST_S0IXS0;
        else if (!it.pgood_all_core) nxt = ST_S0;
      end
      ST_S0S0IX: begin
        if (it.host_sleep_state == HOST_SUSPEND) add_event(EV_SLEEP_SUSPEND);
        deep_ok = 1'b1;
        if (hook_on) add_event(EV_SUSPEND_DONE);
        nxt = ST_S0IX;
      end
      ST_S0IXS0: begin
        deep_ok = 1'b0;
        if (hook_on) add_event(EV_RESUME_INIT);
        nxt = ST_S0;
      end
      ST_S0: begin
        if (!it.pgood_all_core) begin
          add_powerfail();
          nxt = ST_G3;
        end else if (it.slp_valid[0] && it.slp_s3_on) begin
          nxt = ST_S0S3;
        end else if (s0ix_on && it.host_sleep_state == HOST_SUSPEND && it.slp_s0_on) begin
          nxt = ST_S0S0IX;
        end else if (s0ix_on && it.host_sleep_state == HOST_RESUME) begin
          add_event(EV_SLEEP_RESUME);
        end
      end
      ST_S4S5: begin
        add_event(EV_SHUTDOWN);
        add_event(EV_SHUTDOWN_DONE);
        nxt = ST_S5;
      end
      ST_S3S4: nxt = ST_S4;
      ST_S0S3: begin
        add_event(EV_SUSPEND);
        if (hook_on) add_event(EV_SUSPEND_DONE);
        deep_ok = 1'b1;
        if (s0ix_on) add_event(EV_CLEAR_HOST_SLP);
        nxt = ST_S3;
      end
    endcase
    if (cur == ST_S5 && nxt != ST_S5) begin
      s5_run = 1'b0;
      s5_cnt = '0;
    end
    pw_state = nxt;
    if (tick_events.size() == 0) tick_events.push_back(EV_NONE);
    foreach (tick_events[k]) begin
      r.power_state        = nxt;
      r.event_code         = tick_events[k];
      r.last_event         = (k == tick_events.size() - 1);
      r.rsmrst_drive       = rsmrst_lvl;
      r.deep_sleep_allowed = deep_ok;
      r.state_changed      = (nxt != cur);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // signal snapshot that pushes the machine along one leg of its journey
  function automatic item_t shaped_item(flavor_t fl, bit noisy);
    item_t it;
    it                = '0;
    it.exit_request   = noisy && ($urandom_range(0, 2) == 0);
    it.signal_vector  = (SIG_W'($urandom_range(0, 16'hFFFF)) & ~g3s5_mask) |
                        (g3s5_value & g3s5_mask);
    it.slp_valid      = 3'b111;
    it.pgood_all_core = 1'b1;
    it.all_sys_pwrgd  = 1'b1;
    it.rails_ok       = 3'b111;
    it.rsmrst_good    = 1'b1;
    case (fl)
      FL_SLEEP_S3: it.slp_s3_on = 1'b1;
      FL_SLEEP_S4: {it.slp_s3_on, it.slp_s4_on} = 2'b11;
      FL_OFF:      {it.slp_s3_on, it.slp_s4_on, it.slp_s5_on} = 3'b111;
      FL_IX_ENTER: begin
        it.slp_s0_on        = 1'b1;
        it.host_sleep_state = HOST_SUSPEND;
      end
      FL_IX_EXIT: begin
        if (noisy && $urandom_range(0, 1) == 1) it.host_sleep_state = HOST_RESUME;
      end
      FL_PFAIL: it.pgood_all_core = 1'b0;
      FL_NOISE: begin
        it = $urandom;
        if (it.host_sleep_state > HOST_RESUME) it.host_sleep_state = 2'($urandom_range(0, 2));
      end
      default: ;
    endcase
    if (noisy && $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: it.signal_vector = 16'($urandom);
        1: it.slp_valid = 3'($urandom);
        2: {it.slp_s0_on, it.slp_s3_on, it.slp_s4_on, it.slp_s5_on} = 4'($urandom);
        3: {it.pgood_all_core, it.all_sys_pwrgd} = 2'($urandom);
        4: {it.rails_ok, it.rsmrst_good} = 4'($urandom);
        default: it.host_sleep_state = 2'($urandom_range(0, 2));
      endcase
    end
    return it;
  endfunction

  task automatic queue_random(input int count);
    flavor_t fl;
    int      seg;
    int      n;
    n = 0;
    while (n < count) begin
      fl = flavor_t'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) fl = FL_BOOT;
      seg = (fl == FL_BOOT) ? $urandom_range(4, 12) : $urandom_range(1, 6);
      repeat (seg) begin
        if (n < count) begin
          pending_items.push_back(shaped_item(fl, 1'b1));
          n++;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_G3S5_MASK:    g3s5_mask    = data[SIG_W-1:0];
      CFG_G3S5_VALUE:   g3s5_value   = data[SIG_W-1:0];
      CFG_REBOOT_DELAY: reboot_ticks = data[TIMER_W-1:0];
      CFG_S5_MODE:      s5_mode      = data[1:0];
      CFG_S5_TICKS:     s5_ticks     = data[TIMER_W-1:0];
      CFG_S0IX_EN:      s0ix_on      = data[0];
      CFG_RESUME_HOOK:  hook_on      = data[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [SIG_W-1:0] mask, input logic [SIG_W-1:0] value,
                              input logic [TIMER_W-1:0] reboot, input logic [1:0] mode,
                              input logic [TIMER_W-1:0] ticks, input logic s0ix,
                              input logic hook);
    write_reg(CFG_G3S5_MASK, CFG_DATA_W'(mask));
    write_reg(CFG_G3S5_VALUE, CFG_DATA_W'(value));
    write_reg(CFG_REBOOT_DELAY, CFG_DATA_W'(reboot));
    write_reg(CFG_S5_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_S5_TICKS, CFG_DATA_W'(ticks));
    write_reg(CFG_S0IX_EN, CFG_DATA_W'(s0ix));
    write_reg(CFG_RESUME_HOOK, CFG_DATA_W'(hook));
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // every tick raises a result, so an empty scoreboard means the block is idle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: predicts each tick at its transfer
  always @(posedge clk) begin : drive_ticks
    bit offer;
    offer = 1'b0;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_tick(in_item);
        void'(pending_items.pop_front());
      end
      if (push && full) begin
        offer = 1'b1;
      end else if (src_gap > 0) begin
        src_gap--;
      end else if (pending_items.size() != 0) begin
        if (!no_gaps && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7) - 1;
        else offer = 1'b1;
      end
      push <= offer;
      if (offer) in_item <= pending_items[0];
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    bit      take;
    take = 1'b1;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual state %0d event %0d",
                   $time, result.power_state, result.event_code);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("power_state", want.power_state, result.power_state);
          check_field("event_code", want.event_code, result.event_code);
          check_field("last_event", want.last_event, result.last_event);
          check_field("rsmrst_drive", want.rsmrst_drive, result.rsmrst_drive);
          check_field("deep_sleep_allowed", want.deep_sleep_allowed, result.deep_sleep_allowed);
          check_field("state_changed", want.state_changed, result.state_changed);
        end
      end
      if (sink_hold_go && !sink_hold_done) begin
        take = 1'b0;
        sink_hold_cnt++;
        if (sink_hold_cnt >= LONG_HOLD) sink_hold_done = 1'b1;
      end else if (sink_gap > 0) begin
        take = 1'b0;
        sink_gap--;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        take = 1'b0;
        sink_gap = $urandom_range(1, 7) - 1;
      end
      pop <= take;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_phases
    item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed walk: G3 -> S0 -> S0ix -> S0 -> S3 -> S4 -> S5 -> G3
    program_regs(16'hFFFF, 16'hFFFF, 20'd1, S5_TMO_TIMED, 20'd1, 1'b1, 1'b1);
    it = '0;
    pending_items.push_back(it);
    it.exit_request = 1'b1;             // latched, reboot delay counts one tick
    pending_items.push_back(it);
    it = '0;
    pending_items.push_back(it);
    it = shaped_item(FL_BOOT, 1'b0);    // masked signals all ones -> S5
    pending_items.push_back(it);
    it.slp_valid = 3'b011;              // S5 wire not valid: stays, timer starts
    it.slp_s5_on = 1'b1;
    pending_items.push_back(it);
    repeat (5) pending_items.push_back(shaped_item(FL_BOOT, 1'b0));
    it = shaped_item(FL_BOOT, 1'b0);
    it.all_sys_pwrgd = 1'b0;            // S3S0 waits for system power good
    pending_items.push_back(it);
    pending_items.push_back(shaped_item(FL_BOOT, 1'b0));
    it = shaped_item(FL_BOOT, 1'b0);
    it.host_sleep_state = HOST_RESUME;
    pending_items.push_back(it);
    repeat (2) pending_items.push_back(shaped_item(FL_IX_ENTER, 1'b0));
    pending_items.push_back(shaped_item(FL_IX_EXIT, 1'b0));
    pending_items.push_back(shaped_item(FL_BOOT, 1'b0));
    repeat (2) pending_items.push_back(shaped_item(FL_SLEEP_S3, 1'b0));
    repeat (2) pending_items.push_back(shaped_item(FL_SLEEP_S4, 1'b0));
    repeat (5) pending_items.push_back(shaped_item(FL_OFF, 1'b0));
    wait_idle();

    // reset-like settings; sink holds off so the block backs up
    program_regs(16'h0000, 16'h0000, 20'd0, S5_TMO_OFF, 20'd1, 1'b0, 1'b0);
    sink_hold_go = 1'b1;
    queue_random(80);
    wait_idle();

    it.signal_vector = 16'($urandom);
    program_regs(it.signal_vector, it.signal_vector & 16'($urandom), 20'd3, S5_TMO_IMMED,
                 20'd0, 1'b1, 1'b0);
    queue_random(80);
    wait_idle();

    program_regs(16'hFFFF, 16'h0000, 20'hFFFFF, S5_TMO_UNUSED, 20'hFFFFF, 1'b0, 1'b1);
    queue_random(30);
    wait_idle();

    program_regs(16'h00FF, 16'h005A, 20'd2, S5_TMO_TIMED, 20'd3, 1'b1, 1'b1);
    no_gaps = 1'b1;
    queue_random(115);
    wait_idle();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
